// ===== src/rbfd_pkg.sv =====
// Shared types, constants and width helpers for the RGB box-filter downsampler.
`default_nettype none

package rbfd_pkg;

    // Field widths fixed by the pixel and result formats
    localparam int CH_W        = 8;
    localparam int OUT_COL_W   = 12;
    localparam int OUT_ROW_W   = 12;
    localparam int FACTOR_W    = 5;
    localparam int LINE_W_W    = 13;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 4'd1;

    // Register reset values
    localparam logic [FACTOR_W-1:0] FACTOR_RESET     = 5'd1;
    localparam logic [LINE_W_W-1:0] LINE_WIDTH_RESET = 13'd4096;

    // Default sizing of the line store and averaging square
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_FACTOR_DEF = 16;

    // Output queue sizing
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Holdoff after a configuration word while derived registers settle
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Width helpers derived from the module parameters
    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int col_w(input int max_width);
        return $clog2(max_width);
    endfunction

    function automatic int lw_w(input int max_width);
        return $clog2(max_width + 1);
    endfunction

    function automatic int fac_w(input int max_factor);
        return $clog2(max_factor + 1);
    endfunction

    function automatic int sub_w(input int max_factor);
        return $clog2(max_factor);
    endfunction

    function automatic int horiz_w(input int max_factor);
        return CH_W + $clog2(max_factor);
    endfunction

    function automatic int sum_w(input int max_factor);
        return CH_W + 2 * $clog2(max_factor);
    endfunction

    // Reciprocal shift: exact floor division for every dividend in use
    function automatic int shift_k(input int max_width, input int max_factor);
        return max2(lw_w(max_width), sum_w(max_factor)) + $clog2(max_factor);
    endfunction

    function automatic int recip_w(input int max_width, input int max_factor);
        return shift_k(max_width, max_factor) + 1;
    endfunction

    // Horizontal-sum control for one accepted word
    typedef struct packed {
        logic valid;
        logic h_start;
        logic h_done;
    } t_acc;

    // Line-store control for one word in the read-modify-write stages
    typedef struct packed {
        logic close;
        logic first;
    } t_mem;

    // Front-end flags captured at acceptance
    typedef struct packed {
        logic close;
        logic first;
        logic emit;
    } t_ctl;

    // Position tag that travels beside the lanes
    typedef struct packed {
        logic                 emit;
        logic                 end_of_row;
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
    } t_tag;

    // One queued result word
    typedef struct packed {
        logic [CH_W-1:0]      avg_red;
        logic [CH_W-1:0]      avg_green;
        logic [CH_W-1:0]      avg_blue;
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 end_of_row;
    } t_res;

endpackage

`default_nettype wire

// ===== src/rbfd_if.sv =====
// Valid/ready channel interfaces for pixels, results and configuration words.
`default_nettype none

interface rbfd_pix_if;
    logic                      valid;
    logic                      ready;
    logic [rbfd_pkg::CH_W-1:0] red;
    logic [rbfd_pkg::CH_W-1:0] green;
    logic [rbfd_pkg::CH_W-1:0] blue;
    logic                      start_of_frame;

    modport source (output valid, red, green, blue, start_of_frame, input ready);
    modport sink   (input valid, red, green, blue, start_of_frame, output ready);
endinterface

interface rbfd_res_if;
    logic                           valid;
    logic                           ready;
    logic [rbfd_pkg::CH_W-1:0]      avg_red;
    logic [rbfd_pkg::CH_W-1:0]      avg_green;
    logic [rbfd_pkg::CH_W-1:0]      avg_blue;
    logic [rbfd_pkg::OUT_COL_W-1:0] out_col;
    logic [rbfd_pkg::OUT_ROW_W-1:0] out_row;
    logic                           end_of_row;

    modport source (output valid, avg_red, avg_green, avg_blue, out_col, out_row,
                    end_of_row, input ready);
    modport sink   (input valid, avg_red, avg_green, avg_blue, out_col, out_row,
                    end_of_row, output ready);
endinterface

interface rbfd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rbfd_pkg::CFG_IDX_W-1:0]  index;
    logic [rbfd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/rbfd_front.sv =====
// Configuration, position counters, output-column division and tag pipeline.
`default_nettype none

module rbfd_front #(
    parameter int MAX_WIDTH  = rbfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = rbfd_pkg::MAX_FACTOR_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    rbfd_pix_if.sink              i_pix,
    rbfd_cfg_if.sink              i_cfg,
    input  wire                   i_room,
    output logic                  o_reserve,
    output rbfd_pkg::t_acc        o_acc,
    output rbfd_pkg::t_mem        o_mem,
    output logic [rbfd_pkg::col_w(MAX_WIDTH)-1:0]             o_oc,
    output logic [rbfd_pkg::recip_w(MAX_WIDTH, MAX_FACTOR)-1:0] o_recip,
    output rbfd_pkg::t_tag        o_tag
);

    localparam int CW  = rbfd_pkg::col_w(MAX_WIDTH);
    localparam int LWW = rbfd_pkg::lw_w(MAX_WIDTH);
    localparam int FW  = rbfd_pkg::fac_w(MAX_FACTOR);
    localparam int SW  = rbfd_pkg::sub_w(MAX_FACTOR);
    localparam int K   = rbfd_pkg::shift_k(MAX_WIDTH, MAX_FACTOR);
    localparam int MW  = rbfd_pkg::recip_w(MAX_WIDTH, MAX_FACTOR);

    // Configuration and settle holdoff
    logic [rbfd_pkg::FACTOR_W-1:0] r_factor;
    logic [rbfd_pkg::LINE_W_W-1:0] r_line_width;
    logic [1:0]                    r_settle;

    // Position state
    logic [CW-1:0]                  r_in_col,  n_in_col;
    logic [SW-1:0]                  r_sub_col, n_sub_col;
    logic [SW-1:0]                  r_sub_row, n_sub_row;
    logic [rbfd_pkg::OUT_ROW_W-1:0] r_out_row, n_out_row;

    // Derived divisor registers
    logic [MW-1:0]  r_recip;
    logic [LWW-1:0] r_cols_out;

    // Pipeline stages
    rbfd_pkg::t_ctl                 r_s1;
    logic [CW-1:0]                  r_s1_col;
    logic [rbfd_pkg::OUT_ROW_W-1:0] r_s1_row;
    rbfd_pkg::t_ctl                 r_s2;
    logic [CW-1:0]                  r_s2_oc;
    logic [rbfd_pkg::OUT_ROW_W-1:0] r_s2_row;
    rbfd_pkg::t_tag                 r_pos [4];
    rbfd_pkg::t_tag                 n_pos;

    // Combinational signals
    logic [FW-1:0]  w_f;
    logic [LWW-1:0] w_lw;
    logic           w_accept;
    logic           w_sof;
    logic [CW-1:0]  w_col0, w_col1;
    logic [SW-1:0]  w_sc0, w_sc1, w_sr0;
    logic [rbfd_pkg::OUT_ROW_W-1:0] w_row0;
    logic           w_pre_wrap, w_close, w_last_row, w_first, w_emit, w_row_end;
    logic [FW-1:0]  w_sc_inc, w_sr_inc;
    logic [LWW-1:0] w_col_inc;
    logic [CW+MW-1:0]  w_oc_prod;
    logic [LWW+MW-1:0] w_cols_prod;
    logic [MW-1:0]     w_recip_tab [MAX_FACTOR+1];

    // Reciprocal table: ceil(2^K / f) for every legal factor
    assign w_recip_tab[0] = MW'(64'd1 << K);
    for (genvar gi = 1; gi <= MAX_FACTOR; gi++) begin : g_recip
        localparam longint unsigned Div   = longint'(gi);
        localparam longint unsigned Recip = ((64'd1 << K) + Div - 64'd1) / Div;
        assign w_recip_tab[gi] = MW'(Recip);
    end

    // Clamp the registers to their legal ranges
    always_comb begin
        if (r_factor == '0) begin
            w_f = FW'(1);
        end else if (int'(r_factor) > MAX_FACTOR) begin
            w_f = FW'(MAX_FACTOR);
        end else begin
            w_f = FW'(r_factor);
        end
        if (r_line_width == '0) begin
            w_lw = LWW'(1);
        end else if (int'(r_line_width) > MAX_WIDTH) begin
            w_lw = LWW'(MAX_WIDTH);
        end else begin
            w_lw = LWW'(r_line_width);
        end
    end

    // Accept a word only with queue room and settled divisors
    assign i_pix.ready = i_room && (r_settle == 2'd0);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_pix.valid && i_pix.ready;

    // Work out the position of the incoming word and the next counters
    always_comb begin
        w_sof      = i_pix.start_of_frame;
        w_col0     = w_sof ? '0 : r_in_col;
        w_sc0      = w_sof ? '0 : r_sub_col;
        w_sr0      = w_sof ? '0 : r_sub_row;
        w_row0     = w_sof ? '0 : r_out_row;
        w_pre_wrap = LWW'(w_col0) >= w_lw;
        w_col1     = w_pre_wrap ? '0 : w_col0;
        w_sc1      = w_pre_wrap ? '0 : w_sc0;
        w_sc_inc   = FW'(w_sc1) + FW'(1);
        w_sr_inc   = FW'(w_sr0) + FW'(1);
        w_close    = w_sc_inc >= w_f;
        w_last_row = w_sr_inc >= w_f;
        w_first    = w_sr0 == '0;
        w_emit     = w_close && w_last_row;
        w_col_inc  = LWW'(w_col1) + LWW'(1);
        w_row_end  = w_col_inc >= w_lw;

        n_in_col  = r_in_col;
        n_sub_col = r_sub_col;
        n_sub_row = r_sub_row;
        n_out_row = r_out_row;
        if (w_accept) begin
            if (w_row_end) begin
                n_in_col  = '0;
                n_sub_col = '0;
                n_sub_row = w_last_row ? '0 : SW'(w_sr_inc);
                n_out_row = w_last_row ? w_row0 + 1'b1 : w_row0;
            end else begin
                n_in_col  = w_col_inc[CW-1:0];
                n_sub_col = w_close ? '0 : SW'(w_sc_inc);
                n_sub_row = w_sr0;
                n_out_row = w_row0;
            end
        end
    end

    assign o_acc.valid   = w_accept;
    assign o_acc.h_start = w_sof || w_pre_wrap;
    assign o_acc.h_done  = w_close || w_row_end;
    assign o_reserve     = w_accept && w_emit;

    // Output column by reciprocal multiply, and the tag of the next stage
    assign w_oc_prod   = (CW+MW)'(r_s1_col) * (CW+MW)'(r_recip);
    assign w_cols_prod = (LWW+MW)'(w_lw) * (LWW+MW)'(r_recip);

    always_comb begin
        n_pos.emit       = r_s2.emit;
        n_pos.end_of_row = (LWW'(r_s2_oc) + LWW'(1)) == r_cols_out;
        n_pos.out_col    = rbfd_pkg::OUT_COL_W'(r_s2_oc);
        n_pos.out_row    = r_s2_row;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor     <= rbfd_pkg::FACTOR_RESET;
            r_line_width <= rbfd_pkg::LINE_WIDTH_RESET;
            r_settle     <= rbfd_pkg::SETTLE_CYCLES;
            r_in_col     <= '0;
            r_sub_col    <= '0;
            r_sub_row    <= '0;
            r_out_row    <= '0;
            r_s1         <= '0;
            r_s2         <= '0;
            for (int i = 0; i < 4; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_settle <= rbfd_pkg::SETTLE_CYCLES;
                unique case (i_cfg.index)
                    rbfd_pkg::REG_FACTOR: begin
                        r_factor <= i_cfg.data[rbfd_pkg::FACTOR_W-1:0];
                    end
                    rbfd_pkg::REG_LINE_WIDTH: begin
                        r_line_width <= i_cfg.data[rbfd_pkg::LINE_W_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
            r_in_col   <= n_in_col;
            r_sub_col  <= n_sub_col;
            r_sub_row  <= n_sub_row;
            r_out_row  <= n_out_row;
            r_s1.close <= w_accept && w_close;
            r_s1.first <= w_first;
            r_s1.emit  <= w_accept && w_emit;
            r_s2       <= r_s1;
            r_pos[0]   <= n_pos;
            for (int i = 1; i < 4; i++) begin
                r_pos[i] <= r_pos[i-1];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_recip    <= w_recip_tab[w_f];
        r_cols_out <= w_cols_prod[K +: LWW];
        if (w_accept) begin
            r_s1_col <= w_col1;
            r_s1_row <= w_row0;
        end
        r_s2_oc  <= w_oc_prod[K +: CW];
        r_s2_row <= r_s1_row;
    end

    assign o_mem.close = r_s2.close;
    assign o_mem.first = r_s2.first;
    assign o_oc        = r_s2_oc;
    assign o_recip     = r_recip;
    assign o_tag       = r_pos[3];

endmodule

`default_nettype wire

// ===== src/rbfd_lane.sv =====
// One color lane: horizontal sum, column-sum line store and average division.
`default_nettype none

module rbfd_lane #(
    parameter int MAX_WIDTH  = rbfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = rbfd_pkg::MAX_FACTOR_DEF
) (
    input  wire                                                 i_clk,
    input  wire                                                 i_rst_n,
    input  wire  [rbfd_pkg::CH_W-1:0]                           i_px,
    input  rbfd_pkg::t_acc                                      i_acc,
    input  rbfd_pkg::t_mem                                      i_mem,
    input  wire  [rbfd_pkg::col_w(MAX_WIDTH)-1:0]               i_oc,
    input  wire  [rbfd_pkg::recip_w(MAX_WIDTH, MAX_FACTOR)-1:0] i_recip,
    output logic [rbfd_pkg::CH_W-1:0]                           o_avg
);

    localparam int CW = rbfd_pkg::col_w(MAX_WIDTH);
    localparam int HW = rbfd_pkg::horiz_w(MAX_FACTOR);
    localparam int SM = rbfd_pkg::sum_w(MAX_FACTOR);
    localparam int K  = rbfd_pkg::shift_k(MAX_WIDTH, MAX_FACTOR);
    localparam int MW = rbfd_pkg::recip_w(MAX_WIDTH, MAX_FACTOR);

    // Horizontal sum and its pipeline copies
    logic [HW-1:0] r_h;
    logic [HW-1:0] r_h1, r_h2, r_h3;
    logic [HW-1:0] w_h_sum;

    // Line store and read-modify-write stage
    logic [SM-1:0]  r_mem [MAX_WIDTH];
    logic [SM-1:0]  r_rd;
    rbfd_pkg::t_mem r_m3;
    logic [CW-1:0]  r_oc3;
    logic           r_fwd_hit;
    logic [SM-1:0]  r_fwd;
    logic [SM-1:0]  w_base, w_sum;

    // Division by factor squared as two divisions by factor
    logic [SM-1:0]    r_sum4, r_q1;
    logic [SM+MW-1:0] w_q1_prod, w_q2_prod;

    // Accumulate the current partial square row
    assign w_h_sum = (i_acc.h_start ? '0 : r_h) + HW'(i_px);

    // Merge the stored column sum, or the word just written at the same column
    assign w_base = r_fwd_hit ? r_fwd : r_rd;
    assign w_sum  = r_m3.first ? SM'(r_h3) : w_base + SM'(r_h3);

    assign w_q1_prod = (SM+MW)'(r_sum4) * (SM+MW)'(i_recip);
    assign w_q2_prod = (SM+MW)'(r_q1) * (SM+MW)'(i_recip);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h       <= '0;
            r_m3      <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_acc.valid) begin
                r_h <= i_acc.h_done ? '0 : w_h_sum;
            end
            r_m3      <= i_mem;
            r_fwd_hit <= i_mem.close && r_m3.close && (i_oc == r_oc3);
        end
    end

    // Line store: read at stage two, write at stage three
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_oc];
        if (r_m3.close) begin
            r_mem[r_oc3] <= w_sum;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_acc.valid) begin
            r_h1 <= w_h_sum;
        end
        r_h2   <= r_h1;
        r_h3   <= r_h2;
        r_oc3  <= i_oc;
        r_fwd  <= w_sum;
        r_sum4 <= w_sum;
        r_q1   <= w_q1_prod[K +: SM];
        o_avg  <= w_q2_prod[K +: rbfd_pkg::CH_W];
    end

endmodule

`default_nettype wire

// ===== src/rbfd_merge.sv =====
// Merges lane averages with the position tag into a reserved output queue.
`default_nettype none

module rbfd_merge (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  rbfd_pkg::t_tag             i_tag,
    input  wire  [rbfd_pkg::CH_W-1:0]  i_avg_red,
    input  wire  [rbfd_pkg::CH_W-1:0]  i_avg_green,
    input  wire  [rbfd_pkg::CH_W-1:0]  i_avg_blue,
    input  wire                        i_reserve,
    output logic                       o_room,
    rbfd_res_if.source                 o_res
);

    localparam int PW = rbfd_pkg::PTR_W;

    rbfd_pkg::t_res r_fifo [rbfd_pkg::FIFO_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PW:0]    r_count, r_resv;
    rbfd_pkg::t_res w_entry, w_head;
    logic           w_push, w_pop;

    // Combine the three lanes with the tag
    always_comb begin
        w_entry.avg_red    = i_avg_red;
        w_entry.avg_green  = i_avg_green;
        w_entry.avg_blue   = i_avg_blue;
        w_entry.out_col    = i_tag.out_col;
        w_entry.out_row    = i_tag.out_row;
        w_entry.end_of_row = i_tag.end_of_row;
    end

    assign w_push = i_tag.emit;
    assign w_pop  = o_res.valid && o_res.ready;
    assign o_room = r_resv < (PW+1)'(rbfd_pkg::FIFO_DEPTH);

    // Drive the head word
    assign w_head             = r_fifo[r_rd_ptr];
    assign o_res.valid        = r_count != '0;
    assign o_res.avg_red      = w_head.avg_red;
    assign o_res.avg_green    = w_head.avg_green;
    assign o_res.avg_blue     = w_head.avg_blue;
    assign o_res.out_col      = w_head.out_col;
    assign o_res.out_row      = w_head.out_row;
    assign o_res.end_of_row   = w_head.end_of_row;

    // Pointers, fill count and reservations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_resv   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PW+1)'(w_push) - (PW+1)'(w_pop);
            r_resv  <= r_resv + (PW+1)'(i_reserve) - (PW+1)'(w_pop);
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/rgb_box_filter_downsampler.sv =====
// Top level of the RGB box-filter downsampler: front end, three lanes, merge.
//
//  Channel  Role      Word
//  i_pix    sink      red, green, blue, start_of_frame
//  o_res    source    avg_red, avg_green, avg_blue, out_col, out_row, end_of_row
//  i_cfg    sink      index (0 factor, 1 line_width), data
//
//  Takes one pixel per clock; once its last pixel is accepted, a result passes
//  the line-store read-modify-write and the two reciprocal multiplies per lane
//  into the output queue, and is visible the cycle after it is queued.
//  A 16-entry output queue with slot reservation keeps input flowing while
//  results wait; input ready drops only when all slots are reserved, and after
//  any configuration word while the divisor registers reload.
//  Reset clears counters and sets factor 1, line width 4096; the line store is
//  not cleared, since the first row of each group writes it.
`default_nettype none

module rgb_box_filter_downsampler #(
    parameter int MAX_WIDTH  = rbfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FACTOR = rbfd_pkg::MAX_FACTOR_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rbfd_pix_if.sink    i_pix,
    rbfd_res_if.source  o_res,
    rbfd_cfg_if.sink    i_cfg
);

    localparam int CW = rbfd_pkg::col_w(MAX_WIDTH);
    localparam int MW = rbfd_pkg::recip_w(MAX_WIDTH, MAX_FACTOR);

    rbfd_pkg::t_acc             w_acc;
    rbfd_pkg::t_mem             w_mem;
    rbfd_pkg::t_tag             w_tag;
    logic [CW-1:0]              w_oc;
    logic [MW-1:0]              w_recip;
    logic                       w_reserve;
    logic                       w_room;
    logic [rbfd_pkg::CH_W-1:0]  w_avg_red, w_avg_green, w_avg_blue;

    // Position tracking and configuration
    rbfd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_cfg     (i_cfg),
        .i_room    (w_room),
        .o_reserve (w_reserve),
        .o_acc     (w_acc),
        .o_mem     (w_mem),
        .o_oc      (w_oc),
        .o_recip   (w_recip),
        .o_tag     (w_tag)
    );

    // One lane per color
    rbfd_lane #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_lane_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (i_pix.red),
        .i_acc   (w_acc),
        .i_mem   (w_mem),
        .i_oc    (w_oc),
        .i_recip (w_recip),
        .o_avg   (w_avg_red)
    );

    rbfd_lane #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_lane_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (i_pix.green),
        .i_acc   (w_acc),
        .i_mem   (w_mem),
        .i_oc    (w_oc),
        .i_recip (w_recip),
        .o_avg   (w_avg_green)
    );

    rbfd_lane #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_lane_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (i_pix.blue),
        .i_acc   (w_acc),
        .i_mem   (w_mem),
        .i_oc    (w_oc),
        .i_recip (w_recip),
        .o_avg   (w_avg_blue)
    );

    // Combine lanes and queue results
    rbfd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (w_tag),
        .i_avg_red   (w_avg_red),
        .i_avg_green (w_avg_green),
        .i_avg_blue  (w_avg_blue),
        .i_reserve   (w_reserve),
        .o_room      (w_room),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== verif/rbfd_checker.sv =====
// Checker for the RGB box-filter downsampler: predicts each result word and compares it.
`timescale 1ns / 1ps

module rbfd_checker
    import rbfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rbfd_pix_if  i_pix,
    rbfd_res_if  i_res,
    rbfd_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    // Per-channel sums, 16 bits each, as one 48-bit line-store entry
    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } t_rgb_sum;

    // Register copies, taken from the configuration channel
    logic [FACTOR_W-1:0]  factor_reg;
    logic [LINE_W_W-1:0]  line_width_reg;

    // Position and accumulation state
    t_rgb_sum             col_sum_mem [MAX_WIDTH_DEF];
    t_rgb_sum             row_acc;
    logic [12:0]          in_col;
    logic [4:0]           sub_col;
    logic [4:0]           sub_row;
    logic [OUT_ROW_W-1:0] out_row_cnt;

    t_res                 due_px_q [$];
    t_res                 want;
    int                   err_cnt = 0;
    int                   due_cnt = 0;

    assign o_fail_count = err_cnt;
    assign o_pending    = due_cnt;

    // Fold one pixel into the averaging state; queue the downsampled pixel it completes
    function automatic void box_average(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                                        input logic [CH_W-1:0] blue, input logic sof);
        int unsigned f;
        int unsigned lw;
        int unsigned oc;
        int unsigned area;
        t_res        px;
        f  = factor_reg;
        lw = line_width_reg;
        if (f < 1) f = 1;
        if (f > MAX_FACTOR_DEF) f = MAX_FACTOR_DEF;
        if (lw < 1) lw = 1;
        if (lw > MAX_WIDTH_DEF) lw = MAX_WIDTH_DEF;

        // Restart the image on a frame mark
        if (sof) begin
            in_col      = '0;
            sub_col     = '0;
            sub_row     = '0;
            out_row_cnt = '0;
            row_acc     = '0;
        end
        // Close a row left beyond a narrowed line
        if (in_col >= lw) begin
            in_col  = '0;
            sub_col = '0;
            row_acc = '0;
        end

        row_acc.r += red;
        row_acc.g += green;
        row_acc.b += blue;

        // Close the square row: store or add into the column sum, emit on the last row
        if (sub_col + 1 >= f) begin
            oc = in_col / f;
            if (oc >= MAX_WIDTH_DEF) oc = MAX_WIDTH_DEF - 1;
            if (sub_row == 0) begin
                col_sum_mem[oc] = row_acc;
            end else begin
                col_sum_mem[oc].r += row_acc.r;
                col_sum_mem[oc].g += row_acc.g;
                col_sum_mem[oc].b += row_acc.b;
            end
            if (sub_row + 1 >= f) begin
                area          = f * f;
                px.avg_red    = CH_W'(col_sum_mem[oc].r / area);
                px.avg_green  = CH_W'(col_sum_mem[oc].g / area);
                px.avg_blue   = CH_W'(col_sum_mem[oc].b / area);
                px.out_col    = OUT_COL_W'(oc);
                px.out_row    = out_row_cnt;
                px.end_of_row = (oc + 1 == lw / f);
                due_px_q.push_back(px);
            end
            row_acc = '0;
            sub_col = '0;
        end else begin
            sub_col++;
        end

        // Advance the column; wrap the row and step the row group
        in_col++;
        if (in_col >= lw) begin
            in_col  = '0;
            sub_col = '0;
            row_acc = '0;
            if (sub_row + 1 >= f) begin
                sub_row = '0;
                out_row_cnt++;
            end else begin
                sub_row++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            factor_reg     = FACTOR_RESET;
            line_width_reg = LINE_WIDTH_RESET;
            row_acc        = '0;
            in_col         = '0;
            sub_col        = '0;
            sub_row        = '0;
            out_row_cnt    = '0;
            due_px_q.delete();
        end else begin
            // Compare a delivered word with the oldest pixel due
            if (i_res.valid && i_res.ready) begin
                if (due_px_q.size() == 0) begin
                    $error("result word with nothing due: out_col %0d, out_row %0d",
                           i_res.out_col, i_res.out_row);
                    err_cnt++;
                end else begin
                    want = due_px_q.pop_front();
                    if (i_res.avg_red !== want.avg_red) begin
                        $error("avg_red: expected %0d, got %0d", want.avg_red, i_res.avg_red);
                        err_cnt++;
                    end
                    if (i_res.avg_green !== want.avg_green) begin
                        $error("avg_green: expected %0d, got %0d",
                               want.avg_green, i_res.avg_green);
                        err_cnt++;
                    end
                    if (i_res.avg_blue !== want.avg_blue) begin
                        $error("avg_blue: expected %0d, got %0d", want.avg_blue, i_res.avg_blue);
                        err_cnt++;
                    end
                    if (i_res.out_col !== want.out_col) begin
                        $error("out_col: expected %0d, got %0d", want.out_col, i_res.out_col);
                        err_cnt++;
                    end
                    if (i_res.out_row !== want.out_row) begin
                        $error("out_row: expected %0d, got %0d", want.out_row, i_res.out_row);
                        err_cnt++;
                    end
                    if (i_res.end_of_row !== want.end_of_row) begin
                        $error("end_of_row: expected %0d, got %0d",
                               want.end_of_row, i_res.end_of_row);
                        err_cnt++;
                    end
                end
            end
            // Track register writes; unknown indexes leave both registers alone
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_FACTOR)
                    factor_reg = i_cfg.data[FACTOR_W-1:0];
                else if (i_cfg.index == REG_LINE_WIDTH)
                    line_width_reg = i_cfg.data[LINE_W_W-1:0];
            end
            if (i_pix.valid && i_pix.ready)
                box_average(i_pix.red, i_pix.green, i_pix.blue, i_pix.start_of_frame);
        end
        due_cnt = due_px_q.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the RGB box-filter downsampler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import rbfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int RANDOM_PIXELS   = 1000;
    localparam int NO_IDLE_ROWS    = 200;
    localparam int HOLD_PIXELS     = 100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   stall_en = 1'b1;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   rand_pixels = 0;
    int   fail_cnt;
    int   pend_cnt;
    logic any_word;

    rbfd_pix_if pix_ch ();
    rbfd_res_if res_ch ();
    rbfd_cfg_if cfg_ch ();

    rgb_box_filter_downsampler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    rbfd_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_cnt),
        .o_pending    (pend_cnt)
    );

    always #5 i_clk = ~i_clk;

    // End the run when no word moves on any channel for too long
    assign any_word = (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
                      (cfg_ch.valid && cfg_ch.ready);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles <= any_word ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Drive result ready: random stalls, or a long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !(stall_en && $urandom_range(99) < 24);
            end
        end
    end

    // Pick a channel value, biased toward the extremes
    function automatic logic [CH_W-1:0] rand_chan();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return '0;
        if (sel < 20) return '1;
        return CH_W'($urandom);
    endfunction

    // Offer one pixel word, with random gaps, and hold it until accepted
    task automatic send_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                              input logic [CH_W-1:0] blue, input logic sof);
        while (stall_en && $urandom_range(99) < 24) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid          <= 1'b1;
        pix_ch.red            <= red;
        pix_ch.green          <= green;
        pix_ch.blue           <= blue;
        pix_ch.start_of_frame <= sof;
        do @(posedge i_clk); while (!pix_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    // Drain the block, then write both registers (sometimes a spare index too)
    task automatic configure(input logic [CFG_DATA_W-1:0] fac_data,
                             input logic [CFG_DATA_W-1:0] lw_data);
        pix_ch.valid <= 1'b0;
        wait (pend_cnt == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if ($urandom_range(99) < 15)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_reg(REG_FACTOR, fac_data);
        write_reg(REG_LINE_WIDTH, lw_data);
        cfg_ch.valid <= 1'b0;
    endtask

    // Send one image; a broken one is cut short and may restart mid-way
    task automatic send_frame(input int lw_eff, input int rows, input bit broken);
        int              total;
        bit              flat;
        logic [CH_W-1:0] fr;
        logic [CH_W-1:0] fg;
        logic [CH_W-1:0] fb;
        total = lw_eff * rows;
        if (broken) total = $urandom_range(1, total);
        flat = ($urandom_range(99) < 10);
        fr   = $urandom_range(1) ? '1 : '0;
        fg   = $urandom_range(1) ? '1 : '0;
        fb   = $urandom_range(1) ? '1 : '0;
        for (int i = 0; i < total; i++) begin
            send_pixel(flat ? fr : rand_chan(), flat ? fg : rand_chan(), flat ? fb : rand_chan(),
                       (i == 0) || (broken && $urandom_range(99) < 3));
        end
        rand_pixels += total;
    endtask

    // Choose a setting, mostly small factors and lines, and send a few images
    task automatic random_phase();
        int sel;
        int fac_raw;
        int f;
        int lw;
        int rows;
        int frames;
        sel = $urandom_range(99);
        if (sel < 55)      fac_raw = $urandom_range(1, 4);
        else if (sel < 80) fac_raw = $urandom_range(5, 8);
        else if (sel < 92) fac_raw = $urandom_range(9, 15);
        else if (sel < 96) fac_raw = MAX_FACTOR_DEF;
        else if (sel < 98) fac_raw = $urandom_range(17, 31);
        else               fac_raw = 0;
        f = (fac_raw == 0) ? 1 : (fac_raw > MAX_FACTOR_DEF ? MAX_FACTOR_DEF : fac_raw);
        if ($urandom_range(99) < 10)
            lw = $urandom_range(1, f);
        else
            lw = f * $urandom_range(1, f > 4 ? 2 : 6) + $urandom_range(0, f - 1);
        configure({11'($urandom), 5'(fac_raw)}, {3'($urandom), 13'(lw)});
        frames = $urandom_range(1, f > 4 ? 1 : 3);
        for (int k = 0; k < frames; k++) begin
            rows = f * $urandom_range(1, f > 4 ? 1 : 3);
            if ($urandom_range(99) < 30) rows += $urandom_range(0, f - 1);
            send_frame(lw, rows, $urandom_range(99) < 20);
        end
    endtask

    initial begin
        pix_ch.valid          = 1'b0;
        pix_ch.red            = '0;
        pix_ch.green          = '0;
        pix_ch.blue           = '0;
        pix_ch.start_of_frame = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting passes pixels through; a frame mark restarts mid-row
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h0F, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hF0, 1'b1);
        send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
        send_pixel(8'h9A, 8'hBC, 8'hDE, 1'b0);

        // Narrow the line under a row in flight: the next pixel wraps the row
        configure(16'h0001, 16'h0002);
        send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
        send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);

        // Zero factor and zero line width act as 1: every pixel is a row
        configure(16'hFFE0, 16'hE000);
        send_pixel(8'hFF, 8'h00, 8'h80, 1'b1);
        send_pixel(8'h00, 8'hFF, 8'h7F, 1'b0);
        send_pixel(8'h81, 8'h7E, 8'hFF, 1'b0);

        // Oversized factor saturates; a line narrower than it never completes a square
        configure(16'h001F, 16'h0003);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);

        // Factor 2 on an odd line: full-scale average, right column dropped
        configure(16'h0002, 16'h0005);
        for (int i = 0; i < 10; i++)
            send_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);

        rand_pixels = 0;
        while (rand_pixels < RANDOM_PIXELS)
            random_phase();

        // One-pixel rows with no idling on either side
        configure(16'h0001, 16'h0001);
        stall_en = 1'b0;
        send_frame(1, NO_IDLE_ROWS, 1'b0);
        stall_en = 1'b1;

        // Oversized line register; hold results off so the input stalls
        configure(16'h0001, 16'hFFFF);
        hold_req = 1'b1;
        for (int i = 0; i < HOLD_PIXELS; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);

        pix_ch.valid <= 1'b0;
        wait (pend_cnt == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
